FILE: rtl/ipsf_pkg.sv
package ipsf_pkg;

   // item opcodes
   localparam logic [1:0] OP_LOOKUP    = 2'd0;
   localparam logic [1:0] OP_RT_WRITE  = 2'd1;
   localparam logic [1:0] OP_ARP_WRITE = 2'd2;
   localparam logic [1:0] OP_RSVD      = 2'd3;

   // result actions
   localparam logic [2:0] ACT_FORWARD  = 3'd0;
   localparam logic [2:0] ACT_FOR_HOST = 3'd1;
   localparam logic [2:0] ACT_NO_ROUTE = 3'd2;
   localparam logic [2:0] ACT_IGNORED  = 3'd3;
   localparam logic [2:0] ACT_WR_DONE  = 3'd4;

   // csr register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_IP_0  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_IP_1  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_MAC_0 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_MAC_1 = 2'd3;

   // ethertypes that are dropped without lookup
   localparam logic [15:0] ETH_ARP  = 16'h0806;
   localparam logic [15:0] ETH_IPV6 = 16'h86dd;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] ether_type;
      logic [63:0] ip_header_hi;
      logic [63:0] ip_header_mid;
      logic [31:0] ip_dest_addr;
      logic [3:0]  entry_index;
      logic        entry_valid;
      logic [31:0] entry_addr;
      logic [31:0] entry_mask;
      logic [31:0] entry_gateway;
      logic        entry_port;
      logic [47:0] entry_mac;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        out_port;
      logic [31:0] next_hop_ip;
      logic        arp_hit;
      logic [47:0] new_dest_mac;
      logic [47:0] new_src_mac;
      logic [7:0]  new_ttl;
      logic [15:0] new_checksum;
   } rsp_item_type;

   typedef struct packed {
      logic       capture;
      logic       rt_we;
      logic       arp_we;
      logic       rt_rd_en;
      logic       arp_rd_en;
      logic       sel_route;
      logic       sel_arp;
      logic       load_out;
      logic [2:0] action;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       ignored;
      logic       host_hit;
      logic       rt_match;
      logic       arp_match;
   } dp_status_type;

endpackage

FILE: rtl/ipsf_if.sv
interface ipsf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] ether_type;
   logic [63:0] ip_header_hi;
   logic [63:0] ip_header_mid;
   logic [31:0] ip_dest_addr;
   logic [3:0]  entry_index;
   logic        entry_valid;
   logic [31:0] entry_addr;
   logic [31:0] entry_mask;
   logic [31:0] entry_gateway;
   logic        entry_port;
   logic [47:0] entry_mac;

   modport source (
      output valid, opcode, ether_type, ip_header_hi, ip_header_mid, ip_dest_addr,
             entry_index, entry_valid, entry_addr, entry_mask, entry_gateway,
             entry_port, entry_mac,
      input  ready
   );
   modport sink (
      input  valid, opcode, ether_type, ip_header_hi, ip_header_mid, ip_dest_addr,
             entry_index, entry_valid, entry_addr, entry_mask, entry_gateway,
             entry_port, entry_mac,
      output ready
   );
endinterface

interface ipsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic        out_port;
   logic [31:0] next_hop_ip;
   logic        arp_hit;
   logic [47:0] new_dest_mac;
   logic [47:0] new_src_mac;
   logic [7:0]  new_ttl;
   logic [15:0] new_checksum;

   modport source (
      output valid, action, out_port, next_hop_ip, arp_hit, new_dest_mac,
             new_src_mac, new_ttl, new_checksum,
      input  ready
   );
   modport sink (
      input  valid, action, out_port, next_hop_ip, arp_hit, new_dest_mac,
             new_src_mac, new_ttl, new_checksum,
      output ready
   );
endinterface

FILE: rtl/ipsf_ctrl.sv
module ipsf_ctrl import ipsf_pkg::*; #(
   parameter int ROUTE_ENTRIES = 16,
   parameter int ARP_ENTRIES   = 16,
   localparam int RT_IDX_W  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
   localparam int ARP_IDX_W = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dp_status_type        status,
   output ctrl_cmd_type         cmd,
   output logic [RT_IDX_W-1:0]  rt_rd_addr,
   output logic [ARP_IDX_W-1:0] arp_rd_addr
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RWALK  = 3'd2;
   localparam logic [2:0] S_AWALK  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   localparam logic [RT_IDX_W:0]  RT_COUNT  = (RT_IDX_W+1)'(ROUTE_ENTRIES);
   localparam logic [RT_IDX_W:0]  RT_LAST   = (RT_IDX_W+1)'(ROUTE_ENTRIES - 1);
   localparam logic [ARP_IDX_W:0] ARP_COUNT = (ARP_IDX_W+1)'(ARP_ENTRIES);
   localparam logic [ARP_IDX_W:0] ARP_LAST  = (ARP_IDX_W+1)'(ARP_ENTRIES - 1);

   logic [2:0]           state_ff, state_in;
   logic [2:0]           act_ff, act_in;
   logic [RT_IDX_W:0]    rt_cnt_ff, rt_cnt_in;
   logic [ARP_IDX_W:0]   arp_cnt_ff, arp_cnt_in;
   logic                 live_ff, live_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      rt_cnt_in  = rt_cnt_ff;
      arp_cnt_in = arp_cnt_ff;
      live_in    = 1'b0;
      last_in    = 1'b0;
      cmd        = '0;
      cmd.action = act_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.opcode)
               OP_RT_WRITE: begin
                  cmd.rt_we = 1'b1;
                  act_in    = ACT_WR_DONE;
                  state_in  = S_DONE;
               end
               OP_ARP_WRITE: begin
                  cmd.arp_we = 1'b1;
                  act_in     = ACT_WR_DONE;
                  state_in   = S_DONE;
               end
               OP_RSVD: begin
                  act_in   = ACT_IGNORED;
                  state_in = S_DONE;
               end
               OP_LOOKUP: begin
                  if (status.ignored) begin
                     act_in   = ACT_IGNORED;
                     state_in = S_DONE;
                  end else if (status.host_hit) begin
                     act_in   = ACT_FOR_HOST;
                     state_in = S_DONE;
                  end else begin
                     rt_cnt_in = '0;
                     state_in  = S_RWALK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RWALK: begin
            if (live_ff && status.rt_match) begin
               cmd.sel_route = 1'b1;
               act_in        = ACT_FORWARD;
               arp_cnt_in    = '0;
               state_in      = S_AWALK;
            end else if (live_ff && last_ff) begin
               act_in   = ACT_NO_ROUTE;
               state_in = S_DONE;
            end else if (rt_cnt_ff < RT_COUNT) begin
               cmd.rt_rd_en = 1'b1;
               live_in      = 1'b1;
               last_in      = (rt_cnt_ff == RT_LAST);
               rt_cnt_in    = rt_cnt_ff + 1'b1;
            end
         end
         S_AWALK: begin
            if (live_ff && status.arp_match) begin
               cmd.sel_arp = 1'b1;
               state_in    = S_DONE;
            end else if (live_ff && last_ff) begin
               state_in = S_DONE;
            end else if (arp_cnt_ff < ARP_COUNT) begin
               cmd.arp_rd_en = 1'b1;
               live_in       = 1'b1;
               last_in       = (arp_cnt_ff == ARP_LAST);
               arp_cnt_in    = arp_cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= ACT_IGNORED;
         rt_cnt_ff    <= '0;
         arp_cnt_ff   <= '0;
         live_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         rt_cnt_ff    <= rt_cnt_in;
         arp_cnt_ff   <= arp_cnt_in;
         live_ff      <= live_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rt_rd_addr  = rt_cnt_ff[RT_IDX_W-1:0];
   assign arp_rd_addr = arp_cnt_ff[ARP_IDX_W-1:0];

endmodule

FILE: rtl/ipsf_dp.sv
module ipsf_dp import ipsf_pkg::*; #(
   parameter int ROUTE_ENTRIES = 16,
   parameter int ARP_ENTRIES   = 16,
   localparam int RT_IDX_W  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
   localparam int ARP_IDX_W = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_item_type          req_item,
   input  ctrl_cmd_type          cmd,
   input  logic [RT_IDX_W-1:0]   rt_rd_addr,
   input  logic [ARP_IDX_W-1:0]  arp_rd_addr,
   output dp_status_type         status,
   output rsp_item_type          rsp_item
);

   logic [31:0] host_ip0_ff, host_ip1_ff;
   logic [47:0] port_mac0_ff, port_mac1_ff;

   req_item_type item_ff;

   // route table
   logic [31:0] rt_prefix_mem [ROUTE_ENTRIES];
   logic [31:0] rt_mask_mem   [ROUTE_ENTRIES];
   logic [31:0] rt_gw_mem     [ROUTE_ENTRIES];
   logic        rt_port_mem   [ROUTE_ENTRIES];
   logic [ROUTE_ENTRIES-1:0] rt_valid_ff;
   logic [31:0] rt_prefix_rd_ff, rt_mask_rd_ff, rt_gw_rd_ff;
   logic        rt_port_rd_ff, rt_valid_rd_ff;

   // arp table
   logic [31:0] arp_ip_mem  [ARP_ENTRIES];
   logic [47:0] arp_mac_mem [ARP_ENTRIES];
   logic [ARP_ENTRIES-1:0] arp_valid_ff;
   logic [31:0] arp_ip_rd_ff;
   logic [47:0] arp_mac_rd_ff;
   logic        arp_valid_rd_ff;

   logic [31:0] hop_ff;
   logic        port_ff;
   logic        hit_ff;
   logic [47:0] mac_ff;

   logic [18:0] sum_a_ff;
   logic [17:0] sum_b_ff;
   logic [19:0] sum_ff;
   logic [15:0] csum_ff;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [7:0]  ttl_dec;

   logic                 rt_wr_ok, arp_wr_ok;
   logic [RT_IDX_W-1:0]  rt_waddr;
   logic [ARP_IDX_W-1:0] arp_waddr;

   rsp_item_type rsp_ff, rsp_in;

   assign rt_wr_ok  = int'(item_ff.entry_index) < ROUTE_ENTRIES;
   assign arp_wr_ok = int'(item_ff.entry_index) < ARP_ENTRIES;
   assign rt_waddr  = RT_IDX_W'(item_ff.entry_index);
   assign arp_waddr = ARP_IDX_W'(item_ff.entry_index);
   assign ttl_dec   = item_ff.ip_header_mid[63:56] - 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ip0_ff     <= '0;
         host_ip1_ff     <= '0;
         port_mac0_ff    <= '0;
         port_mac1_ff    <= '0;
         rt_valid_ff     <= '0;
         arp_valid_ff    <= '0;
         rt_valid_rd_ff  <= 1'b0;
         arp_valid_rd_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_HOST_IP_0:  host_ip0_ff  <= csr_wdata[31:0];
               CSR_HOST_IP_1:  host_ip1_ff  <= csr_wdata[31:0];
               CSR_PORT_MAC_0: port_mac0_ff <= csr_wdata;
               CSR_PORT_MAC_1: port_mac1_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.rt_we && rt_wr_ok) begin
            rt_valid_ff[rt_waddr] <= item_ff.entry_valid;
         end
         if (cmd.arp_we && arp_wr_ok) begin
            arp_valid_ff[arp_waddr] <= item_ff.entry_valid;
         end
         if (cmd.rt_rd_en) begin
            rt_valid_rd_ff <= rt_valid_ff[rt_rd_addr];
         end
         if (cmd.arp_rd_en) begin
            arp_valid_rd_ff <= arp_valid_ff[arp_rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rt_we && rt_wr_ok) begin
         rt_prefix_mem[rt_waddr] <= item_ff.entry_addr;
         rt_mask_mem[rt_waddr]   <= item_ff.entry_mask;
         rt_gw_mem[rt_waddr]     <= item_ff.entry_gateway;
         rt_port_mem[rt_waddr]   <= item_ff.entry_port;
      end
      if (cmd.rt_rd_en) begin
         rt_prefix_rd_ff <= rt_prefix_mem[rt_rd_addr];
         rt_mask_rd_ff   <= rt_mask_mem[rt_rd_addr];
         rt_gw_rd_ff     <= rt_gw_mem[rt_rd_addr];
         rt_port_rd_ff   <= rt_port_mem[rt_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arp_we && arp_wr_ok) begin
         arp_ip_mem[arp_waddr]  <= item_ff.entry_addr;
         arp_mac_mem[arp_waddr] <= item_ff.entry_mac;
      end
      if (cmd.arp_rd_en) begin
         arp_ip_rd_ff  <= arp_ip_mem[arp_rd_addr];
         arp_mac_rd_ff <= arp_mac_mem[arp_rd_addr];
      end
   end

   // item capture, selected route and arp entry
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      if (cmd.sel_route) begin
         hop_ff  <= (rt_gw_rd_ff != 32'd0) ? rt_gw_rd_ff : item_ff.ip_dest_addr;
         port_ff <= rt_port_rd_ff;
         hit_ff  <= 1'b0;
      end else if (cmd.sel_arp) begin
         hit_ff <= 1'b1;
         mac_ff <= arp_mac_rd_ff;
      end
   end

   // header checksum, checksum field counted as zero, new ttl in place
   always_ff @(posedge clock) begin
      sum_a_ff <= 19'(item_ff.ip_header_hi[63:48]) + 19'(item_ff.ip_header_hi[47:32])
                + 19'(item_ff.ip_header_hi[31:16]) + 19'(item_ff.ip_header_hi[15:0])
                + 19'({ttl_dec, item_ff.ip_header_mid[55:48]});
      sum_b_ff <= 18'(item_ff.ip_header_mid[31:16]) + 18'(item_ff.ip_header_mid[15:0])
                + 18'(item_ff.ip_dest_addr[31:16]) + 18'(item_ff.ip_dest_addr[15:0]);
      sum_ff   <= 20'(sum_a_ff) + 20'(sum_b_ff);
      csum_ff  <= ~fold2;
   end

   assign fold1 = 17'(sum_ff[19:16]) + 17'(sum_ff[15:0]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);

   always_comb begin
      rsp_in        = '0;
      rsp_in.action = cmd.action;
      if (cmd.action == ACT_FORWARD) begin
         rsp_in.out_port     = port_ff;
         rsp_in.next_hop_ip  = hop_ff;
         rsp_in.arp_hit      = hit_ff;
         rsp_in.new_dest_mac = hit_ff ? mac_ff : 48'd0;
         rsp_in.new_src_mac  = port_ff ? port_mac1_ff : port_mac0_ff;
         rsp_in.new_ttl      = ttl_dec;
         rsp_in.new_checksum = csum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.opcode    = item_ff.opcode;
   assign status.ignored   = (item_ff.ether_type == ETH_ARP) ||
                             (item_ff.ether_type == ETH_IPV6);
   assign status.host_hit  = (item_ff.ip_dest_addr == host_ip0_ff) ||
                             (item_ff.ip_dest_addr == host_ip1_ff);
   assign status.rt_match  = rt_valid_rd_ff &&
                             ((item_ff.ip_dest_addr & rt_mask_rd_ff) == rt_prefix_rd_ff);
   assign status.arp_match = arp_valid_rd_ff && (arp_ip_rd_ff == hop_ff);
   assign rsp_item         = rsp_ff;

endmodule

FILE: rtl/ipv4_static_forwarding_engine_top.sv
// items are taken one at a time: a new item is accepted only once the last result is
// loaded into the output register; table writes, ignored and for-host items skip the
// walks, a no-route lookup ends after the first-match walk over the route memory, and a
// forward also walks the arp memory, one entry read per cycle
// reset: synchronous active high, clears state, csr registers and all table valid bits
module ipv4_static_forwarding_engine_top import ipsf_pkg::*; #(
   parameter int ROUTE_ENTRIES = 16,
   parameter int ARP_ENTRIES   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ipsf_req_if.sink              req_ch,
   ipsf_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RT_IDX_W  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int ARP_IDX_W = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;

   ctrl_cmd_type         cmd;
   dp_status_type        status;
   req_item_type         req_item;
   rsp_item_type         rsp_item;
   logic [RT_IDX_W-1:0]  rt_rd_addr;
   logic [ARP_IDX_W-1:0] arp_rd_addr;

   // pack the incoming item for capture in the datapath
   assign req_item.opcode        = req_ch.opcode;
   assign req_item.ether_type    = req_ch.ether_type;
   assign req_item.ip_header_hi  = req_ch.ip_header_hi;
   assign req_item.ip_header_mid = req_ch.ip_header_mid;
   assign req_item.ip_dest_addr  = req_ch.ip_dest_addr;
   assign req_item.entry_index   = req_ch.entry_index;
   assign req_item.entry_valid   = req_ch.entry_valid;
   assign req_item.entry_addr    = req_ch.entry_addr;
   assign req_item.entry_mask    = req_ch.entry_mask;
   assign req_item.entry_gateway = req_ch.entry_gateway;
   assign req_item.entry_port    = req_ch.entry_port;
   assign req_item.entry_mac     = req_ch.entry_mac;

   // sequencer: decode, route walk, arp walk, hand-off to the output register
   ipsf_ctrl #(
      .ROUTE_ENTRIES (ROUTE_ENTRIES),
      .ARP_ENTRIES   (ARP_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd),
      .rt_rd_addr  (rt_rd_addr),
      .arp_rd_addr (arp_rd_addr)
   );

   // tables, csr registers, checksum pipe and output register
   ipsf_dp #(
      .ROUTE_ENTRIES (ROUTE_ENTRIES),
      .ARP_ENTRIES   (ARP_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_item    (req_item),
      .cmd         (cmd),
      .rt_rd_addr  (rt_rd_addr),
      .arp_rd_addr (arp_rd_addr),
      .status      (status),
      .rsp_item    (rsp_item)
   );

   // result item out of the output register
   assign rsp_ch.action       = rsp_item.action;
   assign rsp_ch.out_port     = rsp_item.out_port;
   assign rsp_ch.next_hop_ip  = rsp_item.next_hop_ip;
   assign rsp_ch.arp_hit      = rsp_item.arp_hit;
   assign rsp_ch.new_dest_mac = rsp_item.new_dest_mac;
   assign rsp_ch.new_src_mac  = rsp_item.new_src_mac;
   assign rsp_ch.new_ttl      = rsp_item.new_ttl;
   assign rsp_ch.new_checksum = rsp_item.new_checksum;

   // a result only appears after the sequencer loaded the output register
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.load_out))
      else $error("rsp valid rose without an output load");

   // anything but a forward carries zero route fields
   a_nonfwd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.action != ACT_FORWARD)) |->
      ((rsp_ch.next_hop_ip == 32'd0) && !rsp_ch.arp_hit && (rsp_ch.new_ttl == 8'd0)))
      else $error("non-forward result with route fields set");

   // table writes, walk steps and output load never overlap
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rt_we, cmd.arp_we, cmd.rt_rd_en, cmd.arp_rd_en,
                cmd.sel_route, cmd.sel_arp, cmd.load_out}))
      else $error("overlapping datapath commands");

endmodule

FILE: test/ipsf_fwd_checker.sv
`timescale 1ns / 100ps
module ipsf_fwd_checker import ipsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ipsf_req_if                   req_ch,
   ipsf_rsp_if                   rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int ROUTE_SLOTS = 16;
   localparam int ARP_SLOTS   = 16;

   typedef struct packed {
      logic        valid;
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic        port;
   } route_slot_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [47:0] mac;
   } arp_slot_type;

   route_slot_type route_tbl [ROUTE_SLOTS];
   arp_slot_type   arp_tbl [ARP_SLOTS];
   logic [31:0]    host_ip [2];
   logic [47:0]    port_mac [2];
   rsp_item_type   awaited_rsp [$];

   // ones-complement sum over the header, checksum word taken as zero
   function automatic logic [15:0] header_csum(input logic [63:0] hi, input logic [63:0] mid,
                                               input logic [31:0] dst);
      logic [31:0] sum;
      int          k;
      sum = 32'(dst[31:16]) + 32'(dst[15:0]);
      for (k = 0; k < 4; k++) sum += 32'(hi[16*k +: 16]);
      sum += 32'(mid[63:48]) + 32'(mid[31:16]) + 32'(mid[15:0]);
      sum = 32'(sum[31:16]) + 32'(sum[15:0]);
      sum = sum + (sum >> 16);
      return ~sum[15:0];
   endfunction

   function automatic rsp_item_type forwarding_decision(input req_item_type it);
      rsp_item_type   res;
      route_slot_type slot;
      int             hit_route;
      int             i;
      logic [7:0]     ttl;
      res = '0;
      hit_route = -1;
      if (it.opcode == OP_RT_WRITE || it.opcode == OP_ARP_WRITE) begin
         res.action = ACT_WR_DONE;
      end else if (it.opcode == OP_RSVD || it.ether_type == ETH_ARP ||
                   it.ether_type == ETH_IPV6) begin
         res.action = ACT_IGNORED;
      end else if (it.ip_dest_addr == host_ip[0] || it.ip_dest_addr == host_ip[1]) begin
         res.action = ACT_FOR_HOST;
      end else begin
         for (i = 0; i < ROUTE_SLOTS; i++)
            if (hit_route < 0 && route_tbl[i].valid &&
                (it.ip_dest_addr & route_tbl[i].mask) == route_tbl[i].prefix)
               hit_route = i;
         if (hit_route < 0) begin
            res.action = ACT_NO_ROUTE;
         end else begin
            slot = route_tbl[hit_route];
            res.action = ACT_FORWARD;
            res.out_port = slot.port;
            res.next_hop_ip = (slot.gateway != 32'h0) ? slot.gateway : it.ip_dest_addr;
            for (i = 0; i < ARP_SLOTS; i++)
               if (!res.arp_hit && arp_tbl[i].valid && arp_tbl[i].ip == res.next_hop_ip) begin
                  res.arp_hit = 1'b1;
                  res.new_dest_mac = arp_tbl[i].mac;
               end
            res.new_src_mac = port_mac[slot.port];
            ttl = it.ip_header_mid[63:56] - 8'd1;
            res.new_ttl = ttl;
            res.new_checksum = header_csum(it.ip_header_hi, {ttl, it.ip_header_mid[55:0]},
                                           it.ip_dest_addr);
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      req_item_type it;
      rsp_item_type want;
      int           i;
      if (reset) begin
         for (i = 0; i < ROUTE_SLOTS; i++) route_tbl[i] = '0;
         for (i = 0; i < ARP_SLOTS; i++) arp_tbl[i] = '0;
         host_ip[0] = '0;
         host_ip[1] = '0;
         port_mac[0] = '0;
         port_mac[1] = '0;
         awaited_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HOST_IP_0:  host_ip[0] = csr_wdata[31:0];
               CSR_HOST_IP_1:  host_ip[1] = csr_wdata[31:0];
               CSR_PORT_MAC_0: port_mac[0] = csr_wdata[47:0];
               CSR_PORT_MAC_1: port_mac[1] = csr_wdata[47:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("result with action 0x%0h arrived with nothing expected", rsp_ch.action);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("action", 48'(want.action), 48'(rsp_ch.action));
               check_field("out_port", 48'(want.out_port), 48'(rsp_ch.out_port));
               check_field("next_hop_ip", 48'(want.next_hop_ip), 48'(rsp_ch.next_hop_ip));
               check_field("arp_hit", 48'(want.arp_hit), 48'(rsp_ch.arp_hit));
               check_field("new_dest_mac", want.new_dest_mac, rsp_ch.new_dest_mac);
               check_field("new_src_mac", want.new_src_mac, rsp_ch.new_src_mac);
               check_field("new_ttl", 48'(want.new_ttl), 48'(rsp_ch.new_ttl));
               check_field("new_checksum", 48'(want.new_checksum), 48'(rsp_ch.new_checksum));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            it.opcode        = req_ch.opcode;
            it.ether_type    = req_ch.ether_type;
            it.ip_header_hi  = req_ch.ip_header_hi;
            it.ip_header_mid = req_ch.ip_header_mid;
            it.ip_dest_addr  = req_ch.ip_dest_addr;
            it.entry_index   = req_ch.entry_index;
            it.entry_valid   = req_ch.entry_valid;
            it.entry_addr    = req_ch.entry_addr;
            it.entry_mask    = req_ch.entry_mask;
            it.entry_gateway = req_ch.entry_gateway;
            it.entry_port    = req_ch.entry_port;
            it.entry_mac     = req_ch.entry_mac;
            awaited_rsp.push_back(forwarding_decision(it));
            if (it.opcode == OP_RT_WRITE)
               route_tbl[it.entry_index] = {it.entry_valid, it.entry_addr, it.entry_mask,
                                            it.entry_gateway, it.entry_port};
            else if (it.opcode == OP_ARP_WRITE)
               arp_tbl[it.entry_index] = {it.entry_valid, it.entry_addr, it.entry_mac};
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import ipsf_pkg::*;

   localparam int          HALF_PERIOD  = 10;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 40;
   localparam logic [15:0] ETH_IPV4     = 16'h0800;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int unsigned           cycle_count;
   bit                    no_idle;              // both sides run without gaps when set
   logic [31:0]           addr_pool [8];        // addresses shared by routes, arp and lookups
   logic [31:0]           host_cfg [2];         // host addresses as last programmed

   ipsf_req_if req_ch ();
   ipsf_rsp_if rsp_ch ();

   ipv4_static_forwarding_engine_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ipsf_fwd_checker u_fwd_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // free running clock
   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // watchdog, counts cycles until the limit is hit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL ipv4_static_forwarding_engine_top");
      $finish;
   end

   // result side: random stall before each item, ready held until it is taken
   initial begin : rsp_stall
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // payload onto the request channel
   task automatic drive_fields(input req_item_type it);
      req_ch.opcode        <= it.opcode;
      req_ch.ether_type    <= it.ether_type;
      req_ch.ip_header_hi  <= it.ip_header_hi;
      req_ch.ip_header_mid <= it.ip_header_mid;
      req_ch.ip_dest_addr  <= it.ip_dest_addr;
      req_ch.entry_index   <= it.entry_index;
      req_ch.entry_valid   <= it.entry_valid;
      req_ch.entry_addr    <= it.entry_addr;
      req_ch.entry_mask    <= it.entry_mask;
      req_ch.entry_gateway <= it.entry_gateway;
      req_ch.entry_port    <= it.entry_port;
      req_ch.entry_mac     <= it.entry_mac;
   endtask

   // present one item after a random gap, return at the edge it is taken
   task automatic send(input req_item_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      drive_fields(it);
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // sender holds off until every expected result is back
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_HOST_IP_0) host_cfg[0] = data[31:0];
      if (idx == CSR_HOST_IP_1) host_cfg[1] = data[31:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // registers only change with the engine drained
   task automatic program_ports(input logic [31:0] h0, input logic [31:0] h1,
                                input logic [47:0] m0, input logic [47:0] m1);
      wait_idle();
      csr_write(CSR_HOST_IP_0, 48'(h0));
      csr_write(CSR_HOST_IP_1, 48'(h1));
      csr_write(CSR_PORT_MAC_0, m0);
      csr_write(CSR_PORT_MAC_1, m1);
   endtask

   // every field random, the builders below override what matters
   function automatic req_item_type noise_item();
      req_item_type it;
      it.opcode        = 2'($urandom_range(0, 3));
      it.ether_type    = 16'($urandom);
      it.ip_header_hi  = {$urandom, $urandom};
      it.ip_header_mid = {$urandom, $urandom};
      it.ip_dest_addr  = $urandom;
      it.entry_index   = 4'($urandom);
      it.entry_valid   = 1'($urandom);
      it.entry_addr    = $urandom;
      it.entry_mask    = $urandom;
      it.entry_gateway = $urandom;
      it.entry_port    = 1'($urandom);
      it.entry_mac     = 48'({$urandom, $urandom});
      return it;
   endfunction

   function automatic req_item_type mk_lookup(input logic [31:0] dst, input logic [15:0] etype);
      req_item_type it;
      it = noise_item();
      it.opcode       = OP_LOOKUP;
      it.ether_type   = etype;
      it.ip_dest_addr = dst;
      return it;
   endfunction

   function automatic req_item_type mk_route(input logic [3:0] idx, input logic valid,
                                             input logic [31:0] prefix, input logic [31:0] mask,
                                             input logic [31:0] gw, input logic port);
      req_item_type it;
      it = noise_item();
      it.opcode        = OP_RT_WRITE;
      it.entry_index   = idx;
      it.entry_valid   = valid;
      it.entry_addr    = prefix;
      it.entry_mask    = mask;
      it.entry_gateway = gw;
      it.entry_port    = port;
      return it;
   endfunction

   function automatic req_item_type mk_arp(input logic [3:0] idx, input logic valid,
                                           input logic [31:0] ip, input logic [47:0] mac);
      req_item_type it;
      it = noise_item();
      it.opcode      = OP_ARP_WRITE;
      it.entry_index = idx;
      it.entry_valid = valid;
      it.entry_addr  = ip;
      it.entry_mac   = mac;
      return it;
   endfunction

   function automatic logic [31:0] pick_addr();
      return addr_pool[$urandom_range(0, 7)];
   endfunction

   // mostly well formed traffic: table loads and lookups that hit them
   function automatic req_item_type random_item();
      req_item_type it;
      logic [31:0]  mask;
      logic [31:0]  dst;
      int           len;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         len  = $urandom_range(0, 32);
         mask = (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
         it = mk_route(4'($urandom), $urandom_range(0, 9) != 0, pick_addr() & mask, mask,
                       ($urandom_range(0, 2) == 0) ? 32'h0 : pick_addr(), 1'($urandom));
         // occasionally a random prefix, which never matches where it has bits outside the mask
         if ($urandom_range(0, 19) == 0) it.entry_addr = $urandom;
      end else if (pick < 22) begin
         it = mk_arp(4'($urandom), $urandom_range(0, 7) != 0, pick_addr(),
                     48'({$urandom, $urandom}));
      end else if (pick < 80) begin
         dst = pick_addr();
         if ($urandom_range(0, 3) == 0) dst[7:0] = 8'($urandom);
         if ($urandom_range(0, 19) == 0) dst = host_cfg[$urandom_range(0, 1)];
         it = mk_lookup(dst, ($urandom_range(0, 4) != 0) ? ETH_IPV4 : 16'($urandom));
      end else if (pick < 86) begin
         it = mk_lookup(pick_addr(), $urandom_range(0, 1) ? ETH_ARP : ETH_IPV6);
      end else if (pick < 90) begin
         it = noise_item();
         it.opcode = OP_RSVD;
      end else begin
         it = noise_item();
      end
      return it;
   endfunction

   // one random phase of n items
   task automatic run_random(input int n);
      req_item_type it;
      int           k;
      for (k = 0; k < n; k++) begin
         it = random_item();
         if ($urandom_range(0, 39) == 0) wait_idle();
         send(it);
      end
   endtask

   initial begin : stimulus
      req_item_type it;
      int           i;
      reset     = 1'b1;
      no_idle   = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      host_cfg[0] = '0;
      host_cfg[1] = '0;
      req_ch.valid = 1'b0;
      drive_fields('0);
      addr_pool[0] = 32'hffff_ffff;
      for (i = 1; i < 8; i++) addr_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: both host addresses are zero, so dst zero is for this host
      send(mk_lookup(32'h0, ETH_IPV4));

      program_ports(32'h0a00_0001, 32'hac10_0001, 48'h02a0_b0c0_d0e0, 48'hfeed_0000_beef);
      // empty tables give no route
      send(mk_lookup(32'h0808_0808, ETH_IPV4));
      // reserved opcode, then arp and ipv6 frames
      it = noise_item();
      it.opcode = OP_RSVD;
      send(it);
      send(mk_lookup(32'h0808_0808, ETH_ARP));
      send(mk_lookup(32'h0808_0808, ETH_IPV6));
      // both host addresses
      send(mk_lookup(32'h0a00_0001, ETH_IPV4));
      send(mk_lookup(32'hac10_0001, ETH_IPV4));
      // direct /8 on port 1, default route through a gateway in the last slot,
      // and an entry written with its valid bit clear
      send(mk_route(4'd0, 1'b1, 32'h0a00_0000, 32'hff00_0000, 32'h0, 1'b1));
      send(mk_route(4'd15, 1'b1, 32'h0, 32'h0, 32'h0a00_00fe, 1'b0));
      send(mk_route(4'd5, 1'b0, 32'h0808_0800, 32'hffff_ff00, 32'h0102_0304, 1'b1));
      send(mk_arp(4'd0, 1'b1, 32'h0a00_00fe, 48'hffff_ffff_ffff));
      send(mk_arp(4'd15, 1'b1, 32'h0a01_0203, 48'h1234_5678_9abc));
      send(mk_arp(4'd3, 1'b0, 32'h0a0a_0a0a, 48'h0));
      // ttl of zero wraps to 255
      it = mk_lookup(32'h0a01_0203, ETH_IPV4);
      it.ip_header_mid[63:56] = 8'h00;
      send(it);
      // next hop only in an invalid arp entry: forward without a mac
      send(mk_lookup(32'h0a0a_0a0a, ETH_IPV4));
      // default route, all-ones header
      it = mk_lookup(32'h0808_0808, ETH_IPV4);
      it.ip_header_hi  = '1;
      it.ip_header_mid = '1;
      send(it);
      // all-ones destination, all-zero header
      it = mk_lookup(32'hffff_ffff, ETH_IPV4);
      it.ip_header_hi  = '0;
      it.ip_header_mid = '0;
      send(it);
      // a lower arp slot for the same address wins
      send(mk_arp(4'd1, 1'b1, 32'h0a01_0203, 48'h0000_0000_0001));
      send(mk_lookup(32'h0a01_0203, ETH_IPV4));
      // removing the /8 leaves the default route
      send(mk_route(4'd0, 1'b0, 32'h0a00_0000, 32'hff00_0000, 32'h0, 1'b1));
      send(mk_lookup(32'h0a01_0203, ETH_IPV4));
      // host route with an all-ones gateway
      send(mk_route(4'd1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
      send(mk_lookup(32'hffff_ffff, ETH_IPV4));

      // random phases under several register settings
      program_ports($urandom, $urandom, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      run_random(115);

      no_idle = 1'b1;
      program_ports(32'h0, 32'h0, 48'h0, 48'h0);
      run_random(115);
      no_idle = 1'b0;

      program_ports(32'hffff_ffff, 32'hffff_ffff, '1, '1);
      run_random(115);

      program_ports(addr_pool[2], addr_pool[5], 48'({$urandom, $urandom}),
                    48'({$urandom, $urandom}));
      run_random(110);

      // drain, then leave room for any stray result
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS ipv4_static_forwarding_engine_top");
      end else begin
         $display("FAIL ipv4_static_forwarding_engine_top");
      end
      $finish;
   end

endmodule
